// ----- design/qrsr_pkg.sv -----
// Shared widths, types and fixed-point helpers for the quadratic root and sign range block.
package qrsr_pkg;

  localparam int WORD_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = 2 * WORD_W;
  localparam int RND_W       = PROD_W - FRAC_W;
  localparam int SAT_W       = RND_W + 4;
  localparam int EDGE_W      = WORD_W + 3;
  localparam int SCALE_W     = 16;
  localparam int SPAN_W      = WORD_W + 1;
  localparam int SPAN_PROD_W = SPAN_W + SCALE_W + 1;
  localparam int SLACK_W     = SPAN_PROD_W - SCALE_W;
  localparam int LIM_W       = 31;
  localparam int SQRT_W      = 24;
  localparam int DEN_W       = WORD_W + 2;
  localparam int NUM_W       = DEN_W + FRAC_W;
  localparam int DIV_LAT     = WORD_W + 2;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_DATA_W   = 160;
  localparam int OUT_DATA_W  = 200;

  localparam logic [CFG_IDX_W-1:0] REG_NEAR_ZERO   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLACK_SCALE = 1'd1;

  localparam logic [LIM_W-1:0]   LIM_RESET   = LIM_W'(66);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(66);

  typedef logic signed [WORD_W-1:0]      word_t;
  typedef logic signed [WORD_W:0]        ab_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SAT_W-1:0]       wide_t;
  typedef logic signed [EDGE_W-1:0]      edge_t;
  typedef logic signed [SPAN_PROD_W-1:0] spn_t;
  typedef logic signed [DEN_W-1:0]       den_t;
  typedef logic signed [NUM_W-1:0]       num_t;

  // Operands carried through the front stages
  typedef struct packed {
    word_t c0;
    word_t c1;
    word_t c2;
    word_t xs;
    word_t xe;
    logic  ng;
  } fr_t;

  // Slack window, degenerate-case flags and discriminant, filled stage by stage
  typedef struct packed {
    edge_t lo;
    edge_t hi;
    logic  l2;
    logic  l1;
    word_t d;
    logic  ovd;
    logic  dz;
    logic  dn;
    logic  ovh;
  } mid_t;

  // Per-item context from the end of the front stages to the output
  typedef struct packed {
    word_t c0;
    word_t c1;
    word_t c2;
    word_t xs;
    word_t xe;
    edge_t lo;
    edge_t hi;
    word_t d;
    logic  l2;
    logic  l1;
    logic  dz;
    logic  dn;
    logic  vs;
    logic  ve;
    logic  ovf;
  } ctx_t;

  // Rounded product: add half an LSB, floor-shift by the fraction width
  function automatic logic signed [RND_W-1:0] rprod(input prod_t p);
    prod_t s;
    s = p + (prod_t'(1) <<< (FRAC_W - 1));
    return s[PROD_W-1:FRAC_W];
  endfunction

  // Saturate to the word range; top bit flags saturation
  function automatic logic [WORD_W:0] sat_word(input wide_t v);
    logic [SAT_W-WORD_W:0] up;
    logic [WORD_W:0]       r;
    up = v[SAT_W-1:WORD_W-1];
    if (up == '0 || up == '1) begin
      r = {1'b0, v[WORD_W-1:0]};
    end else if (v[SAT_W-1]) begin
      r = {1'b1, 1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = {1'b1, 1'b0, {(WORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Magnitude of a word as an unsigned value one bit wider
  function automatic logic [WORD_W:0] mag_word(input word_t v);
    ab_t a;
    a = ab_t'(v);
    return a[WORD_W] ? (WORD_W+1)'(0) - a : a;
  endfunction

endpackage

// ----- design/qrsr_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module qrsr_sqrt (
  input  logic                             clk,
  input  logic                             en,
  input  logic [2*qrsr_pkg::SQRT_W-1:0]    rad_i,
  output logic [qrsr_pkg::SQRT_W-1:0]      root_o
);

  localparam int W  = qrsr_pkg::SQRT_W;
  localparam int RW = W + 3;

  logic [RW-1:0]  rem_r  [W+1];
  logic [W-1:0]   root_r [W+1];
  logic [2*W-1:0] rad_r  [W+1];

  always_comb begin
    rem_r[0]  = '0;
    root_r[0] = '0;
    rad_r[0]  = rad_i;
  end

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [RW-1:0]  rem_sh;
    logic [RW-1:0]  trial;
    logic           ge;
    logic [RW-1:0]  rem_nxt;
    logic [W-1:0]   root_nxt;

    always_comb begin
      rem_sh   = {rem_r[k][RW-3:0], rad_r[k][2*W-1:2*W-2]};
      trial    = {1'b0, root_r[k], 2'b01};
      ge       = rem_sh >= trial;
      rem_nxt  = ge ? rem_sh - trial : rem_sh;
      root_nxt = {root_r[k][W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= rem_nxt;
        root_r[k+1] <= root_nxt;
        rad_r[k+1]  <= {rad_r[k][2*W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_r[W];

endmodule

// ----- design/qrsr_div.sv -----
// Pipelined signed divider, truncating, saturated to the word range.
module qrsr_div (
  input  logic                 clk,
  input  logic                 en,
  input  qrsr_pkg::num_t       num_i,
  input  qrsr_pkg::den_t       den_i,
  output qrsr_pkg::word_t      quo_o,
  output logic                 ovf_o
);

  localparam int QW = qrsr_pkg::WORD_W;
  localparam int NW = qrsr_pkg::NUM_W;
  localparam int DW = qrsr_pkg::DEN_W;
  localparam int RW = DW + 1;

  logic [NW-1:0] nm;
  logic [DW-1:0] dm;
  logic          big_nxt;

  logic [RW-1:0] rem_r [QW+1];
  logic [QW-1:0] low_r [QW+1];
  logic [QW-1:0] quo_r [QW+1];
  logic [DW-1:0] dm_r  [QW+1];
  logic          neg_r [QW+1];
  logic          big_r [QW+1];

  logic [QW:0]   fin_nxt;

  always_comb begin
    nm      = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    dm      = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
    big_nxt = DW'(nm[NW-1:QW]) >= dm;
  end

  // Front stage: magnitudes and the out-of-range check on the quotient
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= RW'(nm[NW-1:QW]);
      low_r[0] <= nm[QW-1:0];
      quo_r[0] <= '0;
      dm_r[0]  <= dm;
      neg_r[0] <= num_i[NW-1] ^ den_i[DW-1];
      big_r[0] <= big_nxt;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [RW-1:0] rem_sh;
    logic          ge;

    always_comb begin
      rem_sh = {rem_r[k][RW-2:0], low_r[k][QW-1]};
      ge     = rem_sh >= RW'(dm_r[k]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? rem_sh - RW'(dm_r[k]) : rem_sh;
        low_r[k+1] <= {low_r[k][QW-2:0], 1'b0};
        quo_r[k+1] <= {quo_r[k][QW-2:0], ge};
        dm_r[k+1]  <= dm_r[k];
        neg_r[k+1] <= neg_r[k];
        big_r[k+1] <= big_r[k];
      end
    end
  end

  always_comb begin
    if (neg_r[QW]) begin
      if (big_r[QW] || quo_r[QW] > {1'b1, {(QW-1){1'b0}}}) begin
        fin_nxt = {1'b1, 1'b1, {(QW-1){1'b0}}};
      end else begin
        fin_nxt = {1'b0, QW'(0) - quo_r[QW]};
      end
    end else begin
      if (big_r[QW] || quo_r[QW][QW-1]) begin
        fin_nxt = {1'b1, 1'b0, {(QW-1){1'b1}}};
      end else begin
        fin_nxt = {1'b0, quo_r[QW]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_o <= fin_nxt[QW-1:0];
      ovf_o <= fin_nxt[QW];
    end
  end

endmodule

// ----- design/quadratic_root_sign_ranges_top.sv -----
// Top level: real roots of a Q16.16 quadratic and the sub-intervals of the wanted sign.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------------
//  in_     | slave     | in_tvalid / in_tready   | tdata: c0,c1,c2,start,end; tuser: sign
//  out_    | master    | out_tvalid / out_tready | tdata: roots, ranges, overflow flag
//  cfg_    | slave     | cfg_valid / cfg_ready   | cfg_index, cfg_data; always ready
//
// One item enters per cycle while in_tready is high; each item passes through the seven front
// stages, then the 24-stage square root, then the 34-stage divider.
// Reset (rst_n low, synchronous) empties the pipeline and the output stage and loads
// the register defaults. A stall at the output parks one result in a skid register;
// only while that register is full does the whole pipeline hold and in_tready drop.
module quadratic_root_sign_ranges_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [31:0] coef_constant, [63:32] coef_linear, [95:64] coef_square,
  // [127:96] interval_start, [159:128] interval_end
  input  logic [qrsr_pkg::IN_DATA_W-1:0]       in_tdata,
  // [0] want_negative
  input  logic [0:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [1:0] root_count, [33:2] root_low, [65:34] root_high, [67:66] range_count,
  // [99:68] first_range_start, [131:100] first_range_end,
  // [163:132] second_range_start, [195:164] second_range_end, [196] overflow_flag
  output logic [qrsr_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [qrsr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qrsr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int WW  = qrsr_pkg::WORD_W;
  localparam int FW  = qrsr_pkg::FRAC_W;
  localparam int SQW = qrsr_pkg::SQRT_W;
  localparam int DVL = qrsr_pkg::DIV_LAT;

  // Configuration registers
  logic [qrsr_pkg::LIM_W-1:0]   lim_r;
  logic [qrsr_pkg::SCALE_W-1:0] scale_r;
  logic [WW:0]                  lim_x;

  assign cfg_ready = 1'b1;
  assign lim_x     = (WW+1)'(lim_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r   <= qrsr_pkg::LIM_RESET;
      scale_r <= qrsr_pkg::SCALE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        qrsr_pkg::REG_NEAR_ZERO:   lim_r   <= cfg_data[qrsr_pkg::LIM_W-1:0];
        qrsr_pkg::REG_SLACK_SCALE: scale_r <= cfg_data[qrsr_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance everything unless the skid register holds a parked result
  logic en;
  logic sk_v_r;
  assign en        = !sk_v_r;
  assign in_tready = en;

  // Front stages
  qrsr_pkg::fr_t  fr1_r, fr2_r, fr3_r, fr4_r, fr5_r, fr6_r;
  qrsr_pkg::mid_t mid2_r, mid3_r, mid4_r, mid5_r, mid6_r;
  qrsr_pkg::mid_t mid2_nxt, mid3_nxt, mid4_nxt, mid5_nxt, mid6_nxt;
  qrsr_pkg::ctx_t ctx7_r, ctx7_nxt;
  logic [6:0]     fv_r;

  qrsr_pkg::prod_t p11_r, p20_r, ps_r, pe_r, qs_r, qe_r;
  qrsr_pkg::spn_t  psl_r;
  qrsr_pkg::wide_t dw_r, dw_nxt;
  qrsr_pkg::word_t ms_r, me_r, ts_r, te_r, m2s_r, m2e_r;
  logic [WW:0]     sat_ms, sat_me, sat_ts, sat_te, sat_d, sat_m2s, sat_m2e, sat_fs, sat_fe;
  logic signed [qrsr_pkg::SPAN_W-1:0]  span;
  logic signed [qrsr_pkg::SLACK_W-1:0] slack;
  qrsr_pkg::word_t fs, fe;

  always_comb begin
    span             = qrsr_pkg::SPAN_W'(fr1_r.xe) - qrsr_pkg::SPAN_W'(fr1_r.xs);
    mid2_nxt         = '0;
    mid2_nxt.l2      = (fr1_r.c2 == '0) || (qrsr_pkg::mag_word(fr1_r.c2) < lim_x);
    mid2_nxt.l1      = (fr1_r.c1 == '0) || (qrsr_pkg::mag_word(fr1_r.c1) < lim_x);

    dw_nxt   = qrsr_pkg::wide_t'(qrsr_pkg::rprod(p11_r))
             - (qrsr_pkg::wide_t'(qrsr_pkg::rprod(p20_r)) <<< 2);
    sat_ms   = qrsr_pkg::sat_word(qrsr_pkg::wide_t'(qrsr_pkg::rprod(ps_r)));
    sat_me   = qrsr_pkg::sat_word(qrsr_pkg::wide_t'(qrsr_pkg::rprod(pe_r)));
    slack    = psl_r[qrsr_pkg::SPAN_PROD_W-1:qrsr_pkg::SCALE_W];
    mid3_nxt     = mid2_r;
    mid3_nxt.lo  = qrsr_pkg::edge_t'(fr2_r.xs) - qrsr_pkg::edge_t'(slack);
    mid3_nxt.hi  = qrsr_pkg::edge_t'(fr2_r.xe) + qrsr_pkg::edge_t'(slack);
    mid3_nxt.ovh = sat_ms[WW] | sat_me[WW];

    sat_d    = qrsr_pkg::sat_word(dw_r);
    sat_ts   = qrsr_pkg::sat_word(qrsr_pkg::wide_t'(ms_r) + qrsr_pkg::wide_t'(fr3_r.c1));
    sat_te   = qrsr_pkg::sat_word(qrsr_pkg::wide_t'(me_r) + qrsr_pkg::wide_t'(fr3_r.c1));
    mid4_nxt     = mid3_r;
    mid4_nxt.d   = sat_d[WW-1:0];
    mid4_nxt.ovd = sat_d[WW];
    mid4_nxt.ovh = mid3_r.ovh | sat_ts[WW] | sat_te[WW];

    // Treat a near-zero discriminant as zero
    mid5_nxt     = mid4_r;
    mid5_nxt.dz  = qrsr_pkg::mag_word(mid4_r.d) <= lim_x;
    mid5_nxt.dn  = mid4_r.d[WW-1] && !mid5_nxt.dz;

    sat_m2s  = qrsr_pkg::sat_word(qrsr_pkg::wide_t'(qrsr_pkg::rprod(qs_r)));
    sat_m2e  = qrsr_pkg::sat_word(qrsr_pkg::wide_t'(qrsr_pkg::rprod(qe_r)));
    mid6_nxt     = mid5_r;
    mid6_nxt.ovh = mid5_r.ovh | sat_m2s[WW] | sat_m2e[WW];

    sat_fs   = qrsr_pkg::sat_word(qrsr_pkg::wide_t'(m2s_r) + qrsr_pkg::wide_t'(fr6_r.c0));
    sat_fe   = qrsr_pkg::sat_word(qrsr_pkg::wide_t'(m2e_r) + qrsr_pkg::wide_t'(fr6_r.c0));
    fs       = sat_fs[WW-1:0];
    fe       = sat_fe[WW-1:0];
    ctx7_nxt.c0  = fr6_r.c0;
    ctx7_nxt.c1  = fr6_r.c1;
    ctx7_nxt.c2  = fr6_r.c2;
    ctx7_nxt.xs  = fr6_r.xs;
    ctx7_nxt.xe  = fr6_r.xe;
    ctx7_nxt.lo  = mid6_r.lo;
    ctx7_nxt.hi  = mid6_r.hi;
    ctx7_nxt.d   = mid6_r.d;
    ctx7_nxt.l2  = mid6_r.l2;
    ctx7_nxt.l1  = mid6_r.l1;
    ctx7_nxt.dz  = mid6_r.dz;
    ctx7_nxt.dn  = mid6_r.dn;
    ctx7_nxt.vs  = fr6_r.ng ? (fs <= 0) : (fs >= 0);
    ctx7_nxt.ve  = fr6_r.ng ? (fe <= 0) : (fe >= 0);
    ctx7_nxt.ovf = mid6_r.ovh | sat_fs[WW] | sat_fe[WW] | (mid6_r.ovd & !mid6_r.l2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fr1_r.c0 <= in_tdata[WW-1:0];
      fr1_r.c1 <= in_tdata[2*WW-1:WW];
      fr1_r.c2 <= in_tdata[3*WW-1:2*WW];
      fr1_r.xs <= in_tdata[4*WW-1:3*WW];
      fr1_r.xe <= in_tdata[5*WW-1:4*WW];
      fr1_r.ng <= in_tuser[0];

      p11_r  <= qrsr_pkg::prod_t'(fr1_r.c1) * qrsr_pkg::prod_t'(fr1_r.c1);
      p20_r  <= qrsr_pkg::prod_t'(fr1_r.c2) * qrsr_pkg::prod_t'(fr1_r.c0);
      ps_r   <= qrsr_pkg::prod_t'(fr1_r.c2) * qrsr_pkg::prod_t'(fr1_r.xs);
      pe_r   <= qrsr_pkg::prod_t'(fr1_r.c2) * qrsr_pkg::prod_t'(fr1_r.xe);
      psl_r  <= qrsr_pkg::spn_t'(span) * qrsr_pkg::spn_t'($signed({1'b0, scale_r}));
      fr2_r  <= fr1_r;
      mid2_r <= mid2_nxt;

      dw_r   <= dw_nxt;
      ms_r   <= sat_ms[WW-1:0];
      me_r   <= sat_me[WW-1:0];
      fr3_r  <= fr2_r;
      mid3_r <= mid3_nxt;

      ts_r   <= sat_ts[WW-1:0];
      te_r   <= sat_te[WW-1:0];
      fr4_r  <= fr3_r;
      mid4_r <= mid4_nxt;

      qs_r   <= qrsr_pkg::prod_t'(ts_r) * qrsr_pkg::prod_t'(fr4_r.xs);
      qe_r   <= qrsr_pkg::prod_t'(te_r) * qrsr_pkg::prod_t'(fr4_r.xe);
      fr5_r  <= fr4_r;
      mid5_r <= mid5_nxt;

      m2s_r  <= sat_m2s[WW-1:0];
      m2e_r  <= sat_m2e[WW-1:0];
      fr6_r  <= fr5_r;
      mid6_r <= mid6_nxt;

      ctx7_r <= ctx7_nxt;
    end
  end

  // Square root of D scaled by 2^F; only a positive D matters
  logic [2*SQW-1:0] rad;
  logic [SQW-1:0]   root_s;

  assign rad = (!ctx7_r.dz && !ctx7_r.dn) ?
               (2*SQW)'({ctx7_r.d[WW-2:0], {FW{1'b0}}}) : '0;

  qrsr_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .rad_i  (rad),
    .root_o (root_s)
  );

  qrsr_pkg::ctx_t qctx_r [SQW];
  logic [SQW-1:0] qv_r;

  // Numerators and denominator for the two dividers
  qrsr_pkg::ctx_t qc;
  qrsr_pkg::den_t nc0, nc1, s34, na34, nb34, den_nxt;
  qrsr_pkg::num_t pa_r, pb_r;
  qrsr_pkg::den_t pd_r;
  qrsr_pkg::ctx_t pctx_r;
  logic           pv_r;

  always_comb begin
    qc    = qctx_r[SQW-1];
    nc0   = -qrsr_pkg::den_t'(qc.c0);
    nc1   = -qrsr_pkg::den_t'(qc.c1);
    s34   = qrsr_pkg::den_t'(root_s);
    nb34  = nc1 + s34;
    if (qc.l2) begin
      na34    = nc0;
      den_nxt = qrsr_pkg::den_t'(qc.c1);
    end else if (qc.dz) begin
      na34    = nc1;
      den_nxt = qrsr_pkg::den_t'(qc.c2) <<< 1;
    end else begin
      na34    = nc1 - s34;
      den_nxt = qrsr_pkg::den_t'(qc.c2) <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qctx_r[0] <= ctx7_r;
      for (int i = 1; i < SQW; i++) begin
        qctx_r[i] <= qctx_r[i-1];
      end
      pa_r   <= $signed({na34, {FW{1'b0}}});
      pb_r   <= $signed({nb34, {FW{1'b0}}});
      pd_r   <= den_nxt;
      pctx_r <= qc;
    end
  end

  qrsr_pkg::word_t qa, qb;
  logic            ova, ovb;

  qrsr_div u_div_a (
    .clk   (clk),
    .en    (en),
    .num_i (pa_r),
    .den_i (pd_r),
    .quo_o (qa),
    .ovf_o (ova)
  );

  qrsr_div u_div_b (
    .clk   (clk),
    .en    (en),
    .num_i (pb_r),
    .den_i (pd_r),
    .quo_o (qb),
    .ovf_o (ovb)
  );

  qrsr_pkg::ctx_t dctx_r [DVL];
  logic [DVL-1:0] dv_r;

  // Root count, sort, overflow merge
  qrsr_pkg::ctx_t  dc, f1ctx_nxt, f1ctx_r, f2ctx_r;
  logic [1:0]      nall, f1_nall_r;
  qrsr_pkg::word_t r0, r1, f1_r0_r, f1_r1_r;
  logic            f1v_r;

  always_comb begin
    dc = dctx_r[DVL-1];
    if (dc.l2) begin
      nall = dc.l1 ? 2'd0 : 2'd1;
    end else if (dc.dn) begin
      nall = 2'd0;
    end else begin
      nall = dc.dz ? 2'd1 : 2'd2;
    end
    f1ctx_nxt     = dc;
    f1ctx_nxt.ovf = dc.ovf | ((nall != 2'd0) & ova) | ((nall == 2'd2) & ovb);
    if (nall == 2'd2) begin
      r0 = (qa < qb) ? qa : qb;
      r1 = (qa < qb) ? qb : qa;
    end else begin
      r0 = qa;
      r1 = '0;
    end
  end

  // Keep roots inside the widened interval and clamp them into the start-end interval
  logic            k0_nxt, k1_nxt, k0_r, k1_r, f2v_r;
  qrsr_pkg::edge_t e0, e1;
  qrsr_pkg::word_t cl0_nxt, cl1_nxt, cl0_r, cl1_r;

  always_comb begin
    e0     = qrsr_pkg::edge_t'(f1_r0_r);
    e1     = qrsr_pkg::edge_t'(f1_r1_r);
    k0_nxt = (f1_nall_r != 2'd0) && (e0 >= f1ctx_r.lo) && (e0 <= f1ctx_r.hi);
    k1_nxt = (f1_nall_r == 2'd2) && (e1 >= f1ctx_r.lo) && (e1 <= f1ctx_r.hi);
    if (f1_r0_r < f1ctx_r.xs) begin
      cl0_nxt = f1ctx_r.xs;
    end else if (f1_r0_r > f1ctx_r.xe) begin
      cl0_nxt = f1ctx_r.xe;
    end else begin
      cl0_nxt = f1_r0_r;
    end
    if (f1_r1_r < f1ctx_r.xs) begin
      cl1_nxt = f1ctx_r.xs;
    end else if (f1_r1_r > f1ctx_r.xe) begin
      cl1_nxt = f1ctx_r.xe;
    end else begin
      cl1_nxt = f1_r1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dctx_r[0] <= pctx_r;
      for (int i = 1; i < DVL; i++) begin
        dctx_r[i] <= dctx_r[i-1];
      end
      f1ctx_r   <= f1ctx_nxt;
      f1_nall_r <= nall;
      f1_r0_r   <= r0;
      f1_r1_r   <= r1;
      f2ctx_r   <= f1ctx_r;
      k0_r      <= k0_nxt;
      k1_r      <= k1_nxt;
      cl0_r     <= cl0_nxt;
      cl1_r     <= cl1_nxt;
    end
  end

  // Compact kept roots and build the sign ranges
  logic [1:0]      n, nr;
  qrsr_pkg::word_t kept0, kept1, rs0, re0, rs1, re1;
  logic [qrsr_pkg::OUT_DATA_W-1:0] res_nxt;

  always_comb begin
    n     = {1'b0, k0_r} + {1'b0, k1_r};
    kept0 = k0_r ? cl0_r : (k1_r ? cl1_r : '0);
    kept1 = (k0_r && k1_r) ? cl1_r : '0;
    rs0 = '0;
    re0 = '0;
    rs1 = '0;
    re1 = '0;
    if (n == 2'd0 && !f2ctx_r.vs) begin
      nr = 2'd0;
    end else if (n == 2'd2 && f2ctx_r.vs) begin
      rs0 = f2ctx_r.xs;
      re0 = kept0;
      rs1 = kept1;
      re1 = f2ctx_r.xe;
      nr  = 2'd2;
    end else if (n == 2'd0) begin
      rs0 = f2ctx_r.xs;
      re0 = f2ctx_r.xe;
      nr  = 2'd1;
    end else begin
      rs0 = f2ctx_r.vs ? f2ctx_r.xs : kept0;
      re0 = f2ctx_r.ve ? f2ctx_r.xe : ((n == 2'd2) ? kept1 : kept0);
      nr  = 2'd1;
    end
    res_nxt = {3'b000, f2ctx_r.ovf, re1, rs1, re0, rs0, nr, kept1, kept0, n};
  end

  // Valid bits travel with the data; hold all of them while stalled
  logic [qrsr_pkg::OUT_DATA_W-1:0] out_d_r, sk_d_r;
  logic                            out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r    <= '0;
      qv_r    <= '0;
      pv_r    <= 1'b0;
      dv_r    <= '0;
      f1v_r   <= 1'b0;
      f2v_r   <= 1'b0;
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      if (en) begin
        fv_r  <= {fv_r[5:0], in_tvalid};
        qv_r  <= {qv_r[SQW-2:0], fv_r[6]};
        pv_r  <= qv_r[SQW-1];
        dv_r  <= {dv_r[DVL-2:0], pv_r};
        f1v_r <= dv_r[DVL-1];
        f2v_r <= f1v_r;
        if (f2v_r) begin
          if (!out_v_r || out_tready) begin
            out_d_r <= res_nxt;
            out_v_r <= 1'b1;
          end else begin
            sk_d_r <= res_nxt;
            sk_v_r <= 1'b1;
          end
        end else if (out_tready) begin
          out_v_r <= 1'b0;
        end
      end else if (out_tready) begin
        out_d_r <= sk_d_r;
        sk_v_r  <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule
